### rtl/core/assert_macros.svh
// Assertion macros of the list store, included by its top RTL module.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked at every rising clock edge, disabled while reset is asserted.
`define ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

### rtl/core/clst_pkg.sv
// Package of the compacting list store: sizes, codes and the cell control bundle.
// Used by the channel interfaces and every RTL module; depends on nothing.
package clst_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int DATA_W = 32;
	localparam int MODE_W = 2;
	localparam int STATUS_W = 3;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [DATA_W-1:0] data_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT   = 2'd0,
		MODE_DELETE   = 2'd1,
		MODE_TRAVERSE = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_DELETED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_ELEMENT   = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef struct packed {
		logic ins_en;
		idx_t ins_idx;
		logic shift;
		logic tail_load;
		idx_t tail_idx;
	} cell_ctrl_t;

endpackage

### rtl/core/clst_if.sv
// Valid/ready channel interfaces of the list store: request words and response words.
// Depends on clst_pkg for the field widths.
interface clst_in_if import clst_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

interface clst_out_if import clst_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic signed [DATA_W-1:0] element;
	logic                     last;

	modport source (output valid, output status, output element, output last, input ready);
	modport sink (input valid, input status, input element, input last, output ready);
endinterface

### rtl/core/clst_cell.sv
// One storage cell of the list store chain: holds one entry and takes its neighbor's
// entry, the head entry or an inserted word. Depends on clst_pkg.
module clst_cell import clst_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  idx_t       my_idx,
	input  data_t      nbr_data,
	input  data_t      head_data,
	input  data_t      ins_data,
	output data_t      data
);

	data_t data_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			if (ctrl.tail_load && (ctrl.tail_idx == my_idx)) begin
				data_q <= head_data;
			end else begin
				data_q <= nbr_data;
			end
		end else if (ctrl.ins_en && (ctrl.ins_idx == my_idx)) begin
			data_q <= ins_data;
		end
	end

	assign data = data_q;

endmodule

### rtl/core/clst_chain.sv
// Row of CAPACITY storage cells, each passing its entry down to its lower neighbor, the lowest to the highest.
// Depends on clst_pkg and clst_cell.
module clst_chain import clst_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  data_t      ins_data,
	output data_t      head
);

	data_t cell_data [CAPACITY];

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		data_t nbr;
		if (k == CAPACITY - 1) begin : g_end
			assign nbr = cell_data[0];
		end else begin : g_mid
			assign nbr = cell_data[k+1];
		end
		clst_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.my_idx   (IDX_W'(k)),
			.nbr_data (nbr),
			.head_data(cell_data[0]),
			.ins_data (ins_data),
			.data     (cell_data[k])
		);
	end

	assign head = cell_data[0];

endmodule

### rtl/core/compacting_list_store.sv
// Compacting list store: an insert is accepted and its response word is valid in the next
// cycle. A delete or a traverse on n stored words holds the request side through the accept
// and n rotation steps; a delete answers after its last step, a traverse gives one response
// word per step. On an empty store both answer like an insert. Steps and accepts wait on an
// untaken word.
// Reset (arst_n low) empties the store and drops any pending response; entries hold junk.
module compacting_list_store import clst_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	clst_in_if.sink       req,
	clst_out_if.source    rsp
);

	`include "assert_macros.svh"

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_ROT  = 2'b10
	} state_t;

	state_t     st_q;
	cnt_t       cnt_q;
	cnt_t       len_q;
	cnt_t       step_q;
	logic       found_q;
	logic       is_del_q;
	logic       out_vld_q;
	data_t      val_q;
	status_t    status_q;
	data_t      element_q;
	logic       last_q;

	cell_ctrl_t ctrl;
	data_t      head;
	logic       out_free;
	logic       in_fire;
	logic       rot_adv;
	logic       hit;
	logic       drop;
	logic       fin;
	logic       room;
	logic       res_load;
	status_t    res_status;
	data_t      res_element;
	logic       res_last;

	assign out_free = !out_vld_q || rsp.ready;
	assign req.ready = (st_q == S_IDLE) && out_free;
	assign in_fire = req.valid && req.ready;
	assign rot_adv = (st_q == S_ROT) && out_free;
	assign hit = (head == val_q);
	assign drop = is_del_q && !found_q && hit;
	assign fin = (step_q == cnt_q - CNT_W'(1));
	assign room = (cnt_q < CNT_W'(CAPACITY));

	always_comb begin
		ctrl.ins_en = in_fire && (mode_t'(req.mode) == MODE_INSERT) && room;
		ctrl.ins_idx = IDX_W'(cnt_q);
		ctrl.shift = rot_adv;
		ctrl.tail_load = !drop;
		ctrl.tail_idx = IDX_W'(len_q - CNT_W'(1));
	end

	clst_chain u_chain (
		.clk     (clk),
		.ctrl    (ctrl),
		.ins_data(data_t'(req.value)),
		.head    (head)
	);

	always_comb begin
		res_load = 1'b0;
		res_status = ST_INSERTED;
		res_element = '0;
		res_last = 1'b1;
		if (in_fire) begin
			case (mode_t'(req.mode))
				MODE_INSERT: begin
					res_load = 1'b1;
					res_status = room ? ST_INSERTED : ST_FULL;
				end
				MODE_DELETE: begin
					res_load = (cnt_q == '0);
					res_status = ST_NOT_FOUND;
				end
				MODE_TRAVERSE: begin
					res_load = (cnt_q == '0);
					res_status = ST_EMPTY;
				end
				default: begin
					res_load = 1'b0;
				end
			endcase
		end else if (rot_adv) begin
			if (is_del_q) begin
				res_load = fin;
				res_status = (found_q || drop) ? ST_DELETED : ST_NOT_FOUND;
			end else begin
				res_load = 1'b1;
				res_status = ST_ELEMENT;
				res_element = head;
				res_last = fin;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			len_q <= '0;
			step_q <= '0;
			found_q <= 1'b0;
			is_del_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (ctrl.ins_en) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (in_fire && (cnt_q != '0) &&
					    ((mode_t'(req.mode) == MODE_DELETE) ||
					     (mode_t'(req.mode) == MODE_TRAVERSE))) begin
						st_q <= S_ROT;
						is_del_q <= (mode_t'(req.mode) == MODE_DELETE);
						len_q <= cnt_q;
						step_q <= '0;
						found_q <= 1'b0;
					end
				end
				S_ROT: begin
					if (rot_adv) begin
						step_q <= step_q + CNT_W'(1);
						if (drop) begin
							found_q <= 1'b1;
							len_q <= len_q - CNT_W'(1);
						end
						if (fin) begin
							st_q <= S_IDLE;
							if (found_q || drop) begin
								cnt_q <= cnt_q - CNT_W'(1);
							end
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			val_q <= data_t'(req.value);
		end
		if (res_load) begin
			status_q <= res_status;
			element_q <= res_element;
			last_q <= res_last;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.status = STATUS_W'(status_q);
	assign rsp.element = element_q;
	assign rsp.last = last_q;

	`ASSERT_CLK(a_cnt_bound, cnt_q <= CNT_W'(CAPACITY), "Fill count exceeds capacity.")
	`ASSERT_IMPL(a_ins_count, ctrl.ins_en, ##1 (cnt_q == $past(cnt_q) + CNT_W'(1)), "Insert lost.")
	`ASSERT_IMPL(a_rot_len, st_q == S_ROT, (len_q <= cnt_q) && (step_q < cnt_q), "Bad rotation.")
	`ASSERT_IMPL(a_trav_fin, rot_adv && !is_del_q && fin, ##1 (rsp.valid && rsp.last), "No last.")

endmodule
